// ===== hdl/csr_sparse_matrix_vector_multiply_top_assert.svh =====
// Assertion macros for the sparse matrix-vector block; clock clk, reset rst.
`ifndef CSR_SPARSE_MATRIX_VECTOR_MULTIPLY_TOP_ASSERT_SVH
`define CSR_SPARSE_MATRIX_VECTOR_MULTIPLY_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define CSR_SPMV_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("csr_spmv: same-cycle check failed");
`define CSR_SPMV_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("csr_spmv: next-cycle check failed");
`else
`define CSR_SPMV_ASSERT_NOW(label, ante, cons)
`define CSR_SPMV_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== hdl/csr_spmv_pkg.sv =====
package csr_spmv_pkg;

  localparam int DEF_MAX_ROWS    = 64;
  localparam int DEF_MAX_COLS    = 64;
  localparam int DEF_MAX_ENTRIES = 1024;

  localparam logic [6:0] CFG_RESET = 7'd64;

  typedef enum logic [1:0] {
    KIND_ENTRY   = 2'd0,
    KIND_VECTOR  = 2'd1,
    KIND_COMPUTE = 2'd2,
    KIND_CLEAR   = 2'd3
  } kind_t;

  typedef enum logic {
    REG_ROW_COUNT = 1'b0,
    REG_COL_COUNT = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic load_entry;
    logic load_vector;
    logic clear;
    logic start;
    logic fetch;
    logic vec_read;
    logic mul;
    logic accum;
    logic emit;
    logic next_row;
  } cmd_t;

  typedef struct packed {
    logic k_at_end;
    logic row_match;
    logic last_row;
    logic out_free;
  } status_t;

  function automatic logic [6:0] eff_count(input logic [6:0] cnt, input int limit);
    logic [6:0] res;
    if (cnt == 7'd0) begin
      res = 7'd1;
    end else if (int'(cnt) > limit) begin
      res = 7'(limit);
    end else begin
      res = cnt;
    end
    return res;
  endfunction

endpackage

// ===== hdl/csr_spmv_ctrl.sv =====
module csr_spmv_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             kind,
  output csr_spmv_pkg::cmd_t     cmd,
  input  csr_spmv_pkg::status_t  status
);
  import csr_spmv_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_FETCH = 6'b000010,
    S_CHECK = 6'b000100,
    S_MUL   = 6'b001000,
    S_ACC   = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (kind)
            KIND_ENTRY:  cmd.load_entry  = 1'b1;
            KIND_VECTOR: cmd.load_vector = 1'b1;
            KIND_CLEAR:  cmd.clear       = 1'b1;
            KIND_COMPUTE: begin
              cmd.start  = 1'b1;
              state_next = S_FETCH;
            end
            default: cmd.clear = 1'b1;
          endcase
        end
      end
      S_FETCH: begin
        if (status.k_at_end) begin
          state_next = S_EMIT;
        end else begin
          cmd.fetch  = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status.row_match) begin
          cmd.vec_read = 1'b1;
          state_next   = S_MUL;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.accum  = 1'b1;
        state_next = S_FETCH;
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.last_row) begin
            state_next = S_IDLE;
          end else begin
            cmd.next_row = 1'b1;
            state_next   = S_FETCH;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== hdl/csr_spmv_dp.sv =====
module csr_spmv_dp #(
  parameter int MAX_ROWS    = csr_spmv_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS    = csr_spmv_pkg::DEF_MAX_COLS,
  parameter int MAX_ENTRIES = csr_spmv_pkg::DEF_MAX_ENTRIES
) (
  input  logic                   clk,
  input  logic                   rst,
  input  csr_spmv_pkg::cmd_t     cmd,
  output csr_spmv_pkg::status_t  status,
  input  logic                   cfg_valid,
  input  logic                   cfg_index,
  input  logic [6:0]             cfg_data,
  input  logic [5:0]             row,
  input  logic [5:0]             col,
  input  logic signed [31:0]     entry_value,
  input  logic [5:0]             vector_index,
  input  logic signed [31:0]     vector_value,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [5:0]             row_index,
  output logic signed [63:0]     y_value,
  output logic                   last,
  output logic                   error
);
  import csr_spmv_pkg::*;

  localparam int ET_W = $clog2(MAX_ENTRIES + 1);
  localparam int EA_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int VD   = (MAX_COLS < 64) ? MAX_COLS : 64;
  localparam int VA_W = (VD > 1) ? $clog2(VD) : 1;
  localparam logic [ET_W-1:0] ENTRY_LIMIT = ET_W'(MAX_ENTRIES);
  localparam logic signed [63:0] ACC_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] ACC_MIN = {1'b1, {63{1'b0}}};

  logic [6:0]      row_count;
  logic [6:0]      col_count;
  logic [6:0]      rows;
  logic [6:0]      cols;
  logic [ET_W-1:0] entry_total;
  logic [5:0]      last_loaded_row;
  logic            dropped_flag;
  logic [VD-1:0]   vec_valid;

  logic signed [31:0] ent_val_mem [MAX_ENTRIES];
  logic [VA_W-1:0]    ent_col_mem [MAX_ENTRIES];
  logic [5:0]         ent_row_mem [MAX_ENTRIES];
  logic signed [31:0] vec_mem [VD];

  logic signed [31:0] ent_val_q;
  logic [VA_W-1:0]    ent_col_q;
  logic [5:0]         ent_row_q;
  logic signed [31:0] vec_q;
  logic               vec_hit_q;
  logic signed [31:0] vec_rd;

  logic [ET_W-1:0]    k;
  logic [5:0]         i;
  logic signed [63:0] acc;
  logic signed [63:0] prod;
  logic signed [64:0] sum_wide;
  logic signed [63:0] acc_next;

  logic entry_drop;
  logic vec_drop;

  assign rows = eff_count(row_count, MAX_ROWS);
  assign cols = eff_count(col_count, MAX_COLS);

  assign entry_drop = ({1'b0, row} >= rows) || ({1'b0, col} >= cols) ||
                      (row < last_loaded_row) || (entry_total >= ENTRY_LIMIT);
  assign vec_drop   = ({1'b0, vector_index} >= cols);

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count       <= CFG_RESET;
      col_count       <= CFG_RESET;
      entry_total     <= '0;
      last_loaded_row <= '0;
      dropped_flag    <= 1'b0;
      vec_valid       <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_ROW_COUNT: row_count <= cfg_data;
          REG_COL_COUNT: col_count <= cfg_data;
          default: row_count <= cfg_data;
        endcase
      end
      if (cmd.clear) begin
        entry_total     <= '0;
        last_loaded_row <= '0;
        dropped_flag    <= 1'b0;
        vec_valid       <= '0;
      end
      if (cmd.load_entry) begin
        if (entry_drop) begin
          dropped_flag <= 1'b1;
        end else begin
          entry_total     <= entry_total + ET_W'(1);
          last_loaded_row <= row;
        end
      end
      if (cmd.load_vector) begin
        if (vec_drop) begin
          dropped_flag <= 1'b1;
        end else begin
          vec_valid[vector_index[VA_W-1:0]] <= 1'b1;
        end
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_entry && !entry_drop) begin
      ent_val_mem[entry_total[EA_W-1:0]] <= entry_value;
      ent_col_mem[entry_total[EA_W-1:0]] <= col[VA_W-1:0];
      ent_row_mem[entry_total[EA_W-1:0]] <= row;
    end
    if (cmd.fetch) begin
      ent_val_q <= ent_val_mem[k[EA_W-1:0]];
      ent_col_q <= ent_col_mem[k[EA_W-1:0]];
      ent_row_q <= ent_row_mem[k[EA_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_vector && !vec_drop) begin
      vec_mem[vector_index[VA_W-1:0]] <= vector_value;
    end
    if (cmd.vec_read) begin
      vec_q     <= vec_mem[ent_col_q];
      vec_hit_q <= vec_valid[ent_col_q];
    end
  end

  assign vec_rd = vec_hit_q ? vec_q : 32'sd0;

  assign sum_wide = {acc[63], acc} + {prod[63], prod};
  assign acc_next = (sum_wide[64] != sum_wide[63]) ? (sum_wide[64] ? ACC_MIN : ACC_MAX)
                                                   : sum_wide[63:0];

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      k   <= '0;
      i   <= '0;
      acc <= '0;
    end
    if (cmd.mul) begin
      prod <= ent_val_q * vec_rd;
    end
    if (cmd.accum) begin
      acc <= acc_next;
      k   <= k + ET_W'(1);
    end
    if (cmd.next_row) begin
      i   <= i + 6'd1;
      acc <= '0;
    end
    if (cmd.emit) begin
      row_index <= i;
      y_value   <= acc;
      last      <= status.last_row;
      error     <= dropped_flag;
    end
  end

  assign status.k_at_end  = (k == entry_total);
  assign status.row_match = (ent_row_q == i);
  assign status.last_row  = (({1'b0, i} + 7'd1) == rows);
  assign status.out_free  = !out_valid || out_ready;

endmodule

// ===== hdl/csr_sparse_matrix_vector_multiply_top.sv =====
// Sparse matrix times dense vector in compressed sparse row order, Q16.16 inputs and a
// saturating Q32.32 accumulator. Each input beat is a matrix entry load, a vector element
// load, a clear or a compute; invalid loads are dropped and raise the sticky error flag.
// A compute walks the stored entries once through the one-port entry memory and the single
// shared multiply-accumulate unit, stepping each entry through fetch, check, multiply and
// accumulate states; each row ends in the emit state, which waits while result beats stall.
// No input beat is taken during a compute. Reset and clear take effect at once; there is
// no clearing pass. Registers: index 0 row_count, index 1 col_count, written at any time
// the block is idle.
`include "csr_sparse_matrix_vector_multiply_top_assert.svh"
module csr_sparse_matrix_vector_multiply_top #(
  parameter int MAX_ROWS    = csr_spmv_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS    = csr_spmv_pkg::DEF_MAX_COLS,
  parameter int MAX_ENTRIES = csr_spmv_pkg::DEF_MAX_ENTRIES
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [6:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         kind,
  input  logic [5:0]         row,
  input  logic [5:0]         col,
  input  logic signed [31:0] entry_value,
  input  logic [5:0]         vector_index,
  input  logic signed [31:0] vector_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [5:0]         row_index,
  output logic signed [63:0] y_value,
  output logic               last,
  output logic               error
);
  import csr_spmv_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  csr_spmv_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .kind     (kind),
    .cmd      (cmd),
    .status   (status)
  );

  csr_spmv_dp #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLS    (MAX_COLS),
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .row          (row),
    .col          (col),
    .entry_value  (entry_value),
    .vector_index (vector_index),
    .vector_value (vector_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .row_index    (row_index),
    .y_value      (y_value),
    .last         (last),
    .error        (error)
  );

  `CSR_SPMV_ASSERT_NOW(a_emit_slot_free, cmd.emit, status.out_free)
  `CSR_SPMV_ASSERT_NEXT(a_compute_busy, in_valid && in_ready && (kind == KIND_COMPUTE), !in_ready)
  `CSR_SPMV_ASSERT_NOW(a_load_idle, cmd.load_entry || cmd.load_vector || cmd.clear, in_ready && in_valid)

endmodule
